>>> sv/quadratic_probe_hash_insert_unit_macros.svh
// ============================================================================
// Assertion macros for the quadratic probe hash insert unit
// Concurrent checks that compile away when SYNTH is defined.
// ============================================================================
`ifndef QUADRATIC_PROBE_HASH_INSERT_UNIT_MACROS_SVH
`define QUADRATIC_PROBE_HASH_INSERT_UNIT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define QPHI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define QPHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QPHI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define QPHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/qphi_pkg.sv
// ============================================================================
// qphi_pkg
// Types, codes and constants shared by the hash insert unit modules.
// ============================================================================
package qphi_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ITEM_BITS_DEF   = 32;

    // Size register and everything measured in slots.
    localparam int          SIZE_W     = 11;
    localparam logic [10:0] SIZE_RESET = 11'd1024;
    localparam logic [10:0] SIZE_MIN   = 11'd2;

    // Divider: dividend width and two quotient bits per cycle.
    localparam int DIVD_W    = 32;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_HALF_FULL = 2'd1;
    localparam logic [1:0] ST_NO_SLOT   = 2'd2;
    localparam logic [1:0] ST_ZERO_ITEM = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] key;
        logic [31:0] item;
        logic [9:0]  slot_index;
    } t_in;

    typedef struct packed {
        logic [9:0]  slot;
        logic [31:0] data;
        logic [10:0] probes;
        logic [1:0]  status;
        logic [10:0] item_count;
        logic        over_half;
    } t_out;

    // Kind of result beat the datapath builds.
    typedef enum logic [2:0] {
        EM_PLAIN,
        EM_ZERO,
        EM_HALF,
        EM_WRITE,
        EM_FAIL,
        EM_READ
    } t_emit;

    typedef struct packed {
        logic  div_start;
        logic  div_rd;
        logic  probe_init;
        logic  probe_step;
        logic  mem_rd;
        logic  mem_wr;
        logic  clr_step;
        logic  cnt_clear;
        logic  emit;
        t_emit em;
    } t_cmd;

    typedef struct packed {
        logic item_zero;
        logic half_full;
        logic div_done;
        logic slot_empty;
        logic last_probe;
        logic clr_last;
    } t_stat;

endpackage

>>> sv/qphi_div.sv
// ============================================================================
// qphi_div
// Restoring remainder unit, two dividend bits per cycle.
// ============================================================================
module qphi_div
    import qphi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SIZE_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_dvd;
    logic [SIZE_W-1:0]    r_dvs;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    n_rem_a;
    logic [SIZE_W-1:0]    n_rem;

    // One restoring step: shift in a bit, subtract the divisor if it fits.
    function automatic logic [SIZE_W-1:0] div_step(logic [SIZE_W-1:0] rem, logic b,
                                                   logic [SIZE_W-1:0] d);
        logic [SIZE_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            return SIZE_W'(t - {1'b0, d});
        end
        return t[SIZE_W-1:0];
    endfunction

    always_comb begin
        n_rem_a = div_step(r_rem, r_dvd[DIVD_W-1], r_dvs);
        n_rem   = div_step(n_rem_a, r_dvd[DIVD_W-2], r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVD_W-3:0], 2'b00};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`include "quadratic_probe_hash_insert_unit_macros.svh"

    `QPHI_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_done, r_rem < r_dvs, "remainder not below divisor")

endmodule

>>> sv/qphi_dp.sv
// ============================================================================
// qphi_dp
// Datapath: size register, slot memory, probe registers and result register.
// ============================================================================
module qphi_dp
    import qphi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ITEM_BITS   = ITEM_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  t_in               i_in,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output t_out              o_res
);

    localparam int IW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RD_MOD   = (TABLE_DEPTH > 1024) ? 1024 : TABLE_DEPTH;
    localparam int RD_SH    = 10 + $clog2(RD_MOD);
    localparam int RD_RECIP = ((1 << RD_SH) + RD_MOD - 1) / RD_MOD;

    logic [ITEM_BITS-1:0] mem [TABLE_DEPTH];

    logic [SIZE_W-1:0]    r_table_size;
    logic [SIZE_W-1:0]    r_count;
    logic [IW-1:0]        r_clr;
    logic [ITEM_BITS-1:0] r_item;
    logic [ITEM_BITS-1:0] r_rdata;
    logic [SIZE_W-1:0]    r_pos;
    logic [SIZE_W-1:0]    r_inc;
    logic [SIZE_W-1:0]    r_c;
    t_out                 r_res;

    logic [SIZE_W-1:0]       w_size;
    logic [ITEM_BITS+31:0]   w_in_ext;
    logic [ITEM_BITS-1:0]    w_in_word;
    logic [ITEM_BITS+31:0]   w_item_ext;
    logic [ITEM_BITS+31:0]   w_rd_ext;
    logic [DIVD_W-1:0]       w_dividend;
    logic [SIZE_W-1:0]       w_divisor;
    logic                    w_div_done;
    logic [SIZE_W-1:0]       w_rem;
    logic [21:0]             w_rd_prod;
    logic [21:0]             w_rd_quo;
    logic [21:0]             w_rd_back;
    logic [21:0]             w_rd_diff;
    logic [SIZE_W-1:0]       w_rd_idx;
    logic [SIZE_W:0]         w_pos_sum;
    logic [SIZE_W:0]         w_inc_sum;
    logic [SIZE_W-1:0]       n_pos;
    logic [SIZE_W-1:0]       n_inc;
    logic [SIZE_W-1:0]       n_count;
    logic [IW-1:0]           w_waddr;
    logic [ITEM_BITS-1:0]    w_wdata;
    t_out                    n_res;

    // Effective size is the register clamped into the slots that exist.
    always_comb begin
        if (r_table_size < SIZE_MIN) begin
            w_size = SIZE_MIN;
        end else if (32'(r_table_size) > 32'(TABLE_DEPTH)) begin
            w_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            w_size = r_table_size;
        end
    end

    assign w_in_ext   = {ITEM_BITS'(0), i_in.item};
    assign w_in_word  = w_in_ext[ITEM_BITS-1:0];
    assign w_item_ext = {32'(0), r_item};
    assign w_rd_ext   = {32'(0), r_rdata};

    assign w_dividend = DIVD_W'(i_in.key);
    assign w_divisor  = w_size;

    qphi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Read index: the slot index modulo the table depth, by multiplying with
    // the rounded-up reciprocal. The quotient is exact for ten-bit indexes.
    always_comb begin
        w_rd_prod = {12'd0, i_in.slot_index} * 22'(RD_RECIP);
        w_rd_quo  = w_rd_prod >> RD_SH;
        w_rd_back = w_rd_quo * 22'(RD_MOD);
        w_rd_diff = {12'd0, i_in.slot_index} - w_rd_back;
        w_rd_idx  = w_rd_diff[SIZE_W-1:0];
    end

    // Next probe position and next odd increment, both kept below the size.
    always_comb begin
        w_pos_sum = {1'b0, r_pos} + {1'b0, r_inc};
        w_inc_sum = {1'b0, r_inc} + (SIZE_W + 1)'(2);
        n_pos = (w_pos_sum >= {1'b0, w_size}) ? SIZE_W'(w_pos_sum - {1'b0, w_size})
                                              : w_pos_sum[SIZE_W-1:0];
        n_inc = (w_inc_sum >= {1'b0, w_size}) ? SIZE_W'(w_inc_sum - {1'b0, w_size})
                                              : w_inc_sum[SIZE_W-1:0];
    end

    always_comb begin
        if (i_cmd.cnt_clear) begin
            n_count = '0;
        end else if (i_cmd.mem_wr) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        n_res            = '0;
        n_res.item_count = n_count;
        n_res.over_half  = {n_count, 1'b0} > {1'b0, w_size};
        case (i_cmd.em)
            EM_ZERO:  n_res.status = ST_ZERO_ITEM;
            EM_HALF:  n_res.status = ST_HALF_FULL;
            EM_WRITE: begin
                n_res.slot   = r_pos[9:0];
                n_res.data   = w_item_ext[31:0];
                n_res.probes = r_c;
                n_res.status = ST_DONE;
            end
            EM_FAIL: begin
                n_res.probes = w_size;
                n_res.status = ST_NO_SLOT;
            end
            EM_READ: begin
                n_res.slot   = r_pos[9:0];
                n_res.data   = w_rd_ext[31:0];
                n_res.status = ST_DONE;
            end
            default: n_res.status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
            r_count      <= '0;
            r_clr        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (i_cmd.clr_step) begin
                r_clr <= o_stat.clr_last ? '0 : r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_item <= w_in_word;
        end
        if (i_cmd.probe_init) begin
            r_pos <= i_cmd.div_rd ? w_rd_idx : w_rem;
            r_inc <= SIZE_W'(1);
            r_c   <= '0;
        end else if (i_cmd.probe_step) begin
            r_pos <= n_pos;
            r_inc <= n_inc;
            r_c   <= r_c + 1'b1;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

    // Slot memory: one write port shared by the clearing sweep and inserts.
    assign w_waddr = i_cmd.clr_step ? r_clr : IW'(r_pos);
    assign w_wdata = i_cmd.clr_step ? '0 : r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step || i_cmd.mem_wr) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[IW'(r_pos)];
        end
    end

    always_comb begin
        o_stat.item_zero  = (w_in_word == '0);
        o_stat.half_full  = {r_count, 1'b0} > {1'b0, w_size};
        o_stat.div_done   = w_div_done;
        o_stat.slot_empty = (r_rdata == '0);
        o_stat.last_probe = (r_c == w_size - 1'b1);
        o_stat.clr_last   = (r_clr == IW'(TABLE_DEPTH - 1));
    end

    assign o_res = r_res;

`include "quadratic_probe_hash_insert_unit_macros.svh"

    `QPHI_ASSERT_NOW(a_write_into_empty, i_clk, i_rst_n, i_cmd.mem_wr, r_rdata == '0, "insert overwrites an occupied slot")

endmodule

>>> sv/qphi_ctrl.sv
// ============================================================================
// qphi_ctrl
// Controller: sequences clearing, division, probing and result beats.
// ============================================================================
module qphi_ctrl
    import qphi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_res_valid
);

    typedef enum logic [2:0] {
        S_CLR_RST,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_CLR_OP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   r_is_read;
    logic   n_is_read;
    t_cmd   cmd;

    always_comb begin
        cmd       = '0;
        cmd.em    = EM_PLAIN;
        n_state   = r_state;
        n_is_read = r_is_read;
        unique case (r_state)
            S_CLR_RST: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    cmd.cnt_clear = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_INSERT: begin
                            if (i_stat.item_zero) begin
                                cmd.emit = 1'b1;
                                cmd.em   = EM_ZERO;
                            end else if (i_stat.half_full) begin
                                cmd.emit = 1'b1;
                                cmd.em   = EM_HALF;
                            end else begin
                                cmd.div_start = 1'b1;
                                n_is_read     = 1'b0;
                                n_state       = S_DIV;
                            end
                        end
                        OP_READ: begin
                            // The read index is known at accept.
                            cmd.probe_init = 1'b1;
                            cmd.div_rd     = 1'b1;
                            n_is_read      = 1'b1;
                            n_state        = S_RD;
                        end
                        OP_CLEAR: n_state = S_CLR_OP;
                        default: begin
                            cmd.emit = 1'b1;
                            cmd.em   = EM_PLAIN;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    cmd.probe_init = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (r_is_read) begin
                    cmd.emit = 1'b1;
                    cmd.em   = EM_READ;
                    n_state  = S_IDLE;
                end else if (i_stat.slot_empty) begin
                    cmd.mem_wr = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.em     = EM_WRITE;
                    n_state    = S_IDLE;
                end else if (i_stat.last_probe) begin
                    cmd.emit = 1'b1;
                    cmd.em   = EM_FAIL;
                    n_state  = S_IDLE;
                end else begin
                    cmd.probe_step = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_CLR_OP: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    cmd.cnt_clear = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.em        = EM_PLAIN;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR_RST;
            r_done    <= 1'b0;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= cmd.emit;
            r_is_read <= n_is_read;
        end
    end

    assign o_cmd       = cmd;
    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_done;

`include "quadratic_probe_hash_insert_unit_macros.svh"

    `QPHI_ASSERT_NEXT(a_emit_strobes, i_clk, i_rst_n, cmd.emit, r_done, "result beat not strobed")
    `QPHI_ASSERT_NOW(a_write_needs_empty, i_clk, i_rst_n, cmd.mem_wr, i_stat.slot_empty && !cmd.clr_step, "write without an empty slot")
    `QPHI_ASSERT_NOW(a_probe_after_div, i_clk, i_rst_n, cmd.probe_init, (r_state == S_DIV && i_stat.div_done) || (r_state == S_IDLE && cmd.div_rd), "probe started before home slot known")

endmodule

>>> sv/quadratic_probe_hash_insert_unit.sv
// ============================================================================
// quadratic_probe_hash_insert_unit
// Open-addressed hash table of nonzero item words with quadratic probing.
// ============================================================================
//
//   Channel   Ports                          Direction  Handshake
//   -------   -----------------------------  ---------  ---------------------------
//   command   start, busy, i_in              in         start high while busy low
//   result    o_res_valid, o_res             out        one-cycle strobe, no stall
//   config    i_cfg_we, i_cfg_wdata          in         write on i_cfg_we, no wait
//
// An insert runs from accept through the remainder unit, which finds the home
// slot two key bits per cycle, and then through one slot memory read and one
// check state per probe, until an empty slot is found or the probes run out.
// A slot read skips the remainder unit and goes to the read and check states;
// a refused insert or a no-op gives its beat on the cycle after accept, and a
// clear sweeps TABLE_DEPTH slots, one per cycle, before its beat.
// After reset the block sweeps all TABLE_DEPTH slots to zero, one per cycle,
// with busy held high; configuration writes are still taken during the sweep.
// The receiver cannot stall: each result beat is offered for one cycle only.
//
// The table size register is clamped into [2, TABLE_DEPTH] and is meant to be
// written only while the block is idle. The item word is masked to ITEM_BITS
// before it is stored, so a word that masks to zero is refused.
//
module quadratic_probe_hash_insert_unit
    import qphi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ITEM_BITS   = ITEM_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  t_in               i_in,
    output logic              o_res_valid,
    output t_out              o_res
);

    // Command and status between the controller and the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller decides each step; it sees only the op code of the
    // offered beat, the status flags and the start handshake.
    qphi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_in.op),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy),
        .o_res_valid (o_res_valid)
    );

    // The datapath holds the slot memory, the size register, the item count,
    // the remainder unit and the registered result beat.
    qphi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ITEM_BITS   (ITEM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res       (o_res)
    );

endmodule

>>> verif/quadratic_probe_hash_insert_unit_test.sv
`timescale 1ns / 100ps
// ============================================================================
// quadratic_probe_hash_insert_unit_test
// Self-checking bench for the quadratic probe hash insert unit. A directed
// table of commands covers reset contents, field extremes, refusals, probe
// exhaustion and size clamping. Random phases at several table sizes follow.
// Each beat is held to a typed expectation or to a shadow table prediction.
// ============================================================================
module quadratic_probe_hash_insert_unit_test;
    import qphi_pkg::*;

    localparam int SLOTS = TABLE_DEPTH_DEF;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS = 100;
    // Longest result latency: an insert that walks every slot of the table.
    localparam int TAIL_CYCLES = 2200;
    localparam int MAX_REPORTS = 10;

    // One row of the directed command table. A zero size means the size
    // register is written with zero. The typed flag selects the want beat.
    typedef struct {
        logic [SIZE_W-1:0] size;
        t_in               cmd;
        bit                typed;
        t_out              want;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic              start = 1'b0;
    logic              busy;
    t_in               i_in = '0;
    logic              o_res_valid;
    t_out              o_res;

    // Directed rows may carry a hand-written expectation next to the command.
    bit   typed_flag = 1'b0;
    t_out typed_want = '0;

    // Shadow state of the block, updated at every accepted command beat and size write.
    logic [31:0]       shadow_slots [SLOTS];
    int unsigned       shadow_count = 0;
    logic [SIZE_W-1:0] shadow_size = SIZE_RESET;

    t_out      pending_beats [$];
    t_stim_row directed_rows [$];

    int unsigned mismatches = 0;
    int unsigned beats_seen = 0;
    int unsigned n_placed = 0;
    int unsigned n_refused = 0;
    int unsigned n_exhausted = 0;
    int unsigned n_reads = 0;
    int unsigned n_clears = 0;
    logic [SIZE_W-1:0] drv_size = SIZE_RESET;

    quadratic_probe_hash_insert_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
    end

    // The size register is clamped into [2, depth] wherever it is used.
    function automatic int unsigned clamped_size(input logic [SIZE_W-1:0] raw);
        int unsigned sz;
        sz = 32'(raw);
        if (sz < 2) sz = 2;
        if (sz > SLOTS) sz = SLOTS;
        return sz;
    endfunction

    // Applies one command to the shadow table and returns the beat it causes.
    function automatic t_out predict_table_op(input t_in cmd);
        t_out        r;
        int unsigned sz;
        int unsigned home;
        int unsigned offs;
        int unsigned idx;
        int unsigned c;
        bit          placed;
        r = '0;
        sz = clamped_size(shadow_size);
        placed = 1'b0;
        case (cmd.op)
            OP_INSERT: begin
                if (cmd.item == '0) begin
                    r.status = ST_ZERO_ITEM;
                end else if (shadow_count * 2 > sz) begin
                    r.status = ST_HALF_FULL;
                end else begin
                    home = cmd.key % sz;
                    offs = 0;
                    // Offsets follow c squared, built up as sums of odd numbers.
                    for (c = 0; c < sz && !placed; c++) begin
                        idx = (home + offs) % sz;
                        if (shadow_slots[idx] == '0) begin
                            shadow_slots[idx] = cmd.item;
                            shadow_count = shadow_count + 1;
                            r.slot = idx[9:0];
                            r.data = cmd.item;
                            r.probes = c[SIZE_W-1:0];
                            placed = 1'b1;
                        end else begin
                            offs = (offs + 2 * c + 1) % sz;
                        end
                    end
                    if (!placed) begin
                        r.status = ST_NO_SLOT;
                        r.probes = sz[SIZE_W-1:0];
                    end
                end
            end
            OP_READ: begin
                r.slot = cmd.slot_index;
                r.data = shadow_slots[cmd.slot_index];
            end
            OP_CLEAR: begin
                foreach (shadow_slots[i]) shadow_slots[i] = '0;
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        r.item_count = shadow_count[SIZE_W-1:0];
        r.over_half = (shadow_count * 2 > sz);
        return r;
    endfunction

    // Result checking and prediction both run on the clock edge, reading the
    // values that were present just before it.
    always @(posedge i_clk) begin
        t_out exp_beat;
        t_out pred;
        if (i_rst_n) begin
            if (o_res_valid) begin
                beats_seen++;
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: slot %0d data %h status %0d",
                                 o_res.slot, o_res.data, o_res.status);
                end else begin
                    exp_beat = pending_beats.pop_front();
                    if (o_res.slot !== exp_beat.slot || o_res.data !== exp_beat.data ||
                        o_res.probes !== exp_beat.probes ||
                        o_res.status !== exp_beat.status ||
                        o_res.item_count !== exp_beat.item_count ||
                        o_res.over_half !== exp_beat.over_half) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("beat %0d mismatch, expected slot %0d data %h probes %0d",
                                     beats_seen, exp_beat.slot, exp_beat.data,
                                     exp_beat.probes);
                            $display("    status %0d count %0d half %0d, got slot %0d data %h",
                                     exp_beat.status, exp_beat.item_count,
                                     exp_beat.over_half, o_res.slot, o_res.data);
                            $display("    probes %0d status %0d count %0d half %0d",
                                     o_res.probes, o_res.status, o_res.item_count,
                                     o_res.over_half);
                        end
                    end
                end
            end
            if (i_cfg_we)
                shadow_size = i_cfg_wdata;
            if (start && !busy) begin
                pred = predict_table_op(i_in);
                case (i_in.op)
                    OP_INSERT: begin
                        if (pred.status == ST_DONE) n_placed++;
                        else if (pred.status == ST_NO_SLOT) n_exhausted++;
                        else n_refused++;
                    end
                    OP_READ:  n_reads++;
                    OP_CLEAR: n_clears++;
                    default: begin
                    end
                endcase
                pending_beats.push_back(typed_flag ? typed_want : pred);
            end
        end
    end

    function automatic t_in make_cmd(input logic [1:0] op, input logic [30:0] key,
                                     input logic [31:0] item, input logic [9:0] idx);
        t_in c;
        c.op = op;
        c.key = key;
        c.item = item;
        c.slot_index = idx;
        return c;
    endfunction

    function automatic t_out make_beat(input logic [9:0] slot, input logic [31:0] data,
                                       input logic [10:0] probes, input logic [1:0] status,
                                       input logic [10:0] count, input logic half);
        t_out b;
        b.slot = slot;
        b.data = data;
        b.probes = probes;
        b.status = status;
        b.item_count = count;
        b.over_half = half;
        return b;
    endfunction

    task automatic add_row(input logic [SIZE_W-1:0] size, input t_in cmd, input bit typed,
                           input t_out want);
        t_stim_row row;
        row.size = size;
        row.cmd = cmd;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // Offers one command beat until it is accepted, then drops start for the gap if it is nonzero.
    task automatic send_cmd(input t_in cmd, input bit typed, input t_out want, input int gap);
        start <= 1'b1;
        i_in <= cmd;
        typed_flag <= typed;
        typed_want <= want;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every expected beat is back and the block
    // is idle. The check is made on the falling edge so that it never races
    // the checker.
    task automatic wait_table_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_beats.size() != 0 || busy);
        @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        wait_table_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= size;
        drv_size = size;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in random_cmd(input int unsigned sz);
        t_in         c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) c.op = OP_INSERT;
        else if (pick < 90) c.op = OP_READ;
        else if (pick < 94) c.op = OP_CLEAR;
        else c.op = OP_NONE;
        c.key = ($urandom_range(0, 1) == 0) ? 31'($urandom)
                                            : 31'($urandom_range(0, 4 * sz));
        c.item = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
        c.slot_index = ($urandom_range(0, 4) != 0) ? 10'($urandom_range(0, sz - 1))
                                                   : 10'($urandom);
        return c;
    endfunction

    initial begin
        logic [SIZE_W-1:0] phase_sizes [RANDOM_PHASES];
        t_stim_row row;
        t_in       cmd;
        int        gap;
        bit        burst;

        // Directed rows. Reset state and refusals are typed in by hand.
        add_row(11'd1024, make_cmd(OP_READ, 31'd0, 32'd0, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd0, 1'b0));
        add_row(11'd1024, make_cmd(OP_READ, 31'h7FFFFFFF, 32'hFFFFFFFF, 10'd1023), 1,
                make_beat(10'd1023, 32'd0, 11'd0, ST_DONE, 11'd0, 1'b0));
        add_row(11'd1024, make_cmd(OP_NONE, 31'h7FFFFFFF, 32'hFFFFFFFF, 10'd1023), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd0, 1'b0));
        add_row(11'd1024, make_cmd(OP_INSERT, 31'h7FFFFFFF, 32'd0, 10'd1023), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_ZERO_ITEM, 11'd0, 1'b0));
        add_row(11'd1024, make_cmd(OP_INSERT, 31'd0, 32'hFFFFFFFF, 10'd0), 1,
                make_beat(10'd0, 32'hFFFFFFFF, 11'd0, ST_DONE, 11'd1, 1'b0));
        add_row(11'd1024, make_cmd(OP_INSERT, 31'h7FFFFFFF, 32'd1, 10'd0), 1,
                make_beat(10'd1023, 32'd1, 11'd0, ST_DONE, 11'd2, 1'b0));
        add_row(11'd1024, make_cmd(OP_INSERT, 31'd1024, 32'h80000000, 10'd0), 1,
                make_beat(10'd1, 32'h80000000, 11'd1, ST_DONE, 11'd3, 1'b0));
        add_row(11'd1024, make_cmd(OP_INSERT, 31'd0, 32'h5A5A5A5A, 10'd0), 0, '0);
        add_row(11'd1024, make_cmd(OP_READ, 31'd0, 32'd0, 10'd4), 0, '0);
        add_row(11'd1024, make_cmd(OP_READ, 31'd0, 32'd0, 10'd1023), 0, '0);
        add_row(11'd1024, make_cmd(OP_CLEAR, 31'h55555555, 32'hAAAAAAAA, 10'h2AA), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd0, 1'b0));
        add_row(11'd1024, make_cmd(OP_READ, 31'd0, 32'd0, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd0, 1'b0));
        // Smallest table: one wrap of the probe, then the half-full refusal,
        // which yields to the zero-item refusal.
        add_row(11'd2, make_cmd(OP_INSERT, 31'd5, 32'd7, 10'd0), 1,
                make_beat(10'd1, 32'd7, 11'd0, ST_DONE, 11'd1, 1'b0));
        add_row(11'd2, make_cmd(OP_INSERT, 31'd1, 32'd9, 10'd0), 1,
                make_beat(10'd0, 32'd9, 11'd1, ST_DONE, 11'd2, 1'b1));
        add_row(11'd2, make_cmd(OP_INSERT, 31'd0, 32'd3, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_HALF_FULL, 11'd2, 1'b1));
        add_row(11'd2, make_cmd(OP_INSERT, 31'd0, 32'd0, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_ZERO_ITEM, 11'd2, 1'b1));
        // A read beyond the table size still reaches the raw store.
        add_row(11'd2, make_cmd(OP_READ, 31'd0, 32'd0, 10'd1000), 1,
                make_beat(10'd1000, 32'd0, 11'd0, ST_DONE, 11'd2, 1'b1));
        // With sixteen slots the probe only visits offsets 0, 1, 4 and 9, so
        // four items on those slots leave no empty slot for a key with home slot 0.
        add_row(11'd16, make_cmd(OP_CLEAR, 31'd0, 32'd0, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd0, 1'b0));
        add_row(11'd16, make_cmd(OP_INSERT, 31'd0, 32'h11, 10'd0), 0, '0);
        add_row(11'd16, make_cmd(OP_INSERT, 31'd17, 32'h22, 10'd0), 0, '0);
        add_row(11'd16, make_cmd(OP_INSERT, 31'd4, 32'h44, 10'd0), 0, '0);
        add_row(11'd16, make_cmd(OP_INSERT, 31'd9, 32'h99, 10'd0), 0, '0);
        add_row(11'd16, make_cmd(OP_INSERT, 31'd32, 32'hDEAD, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd16, ST_NO_SLOT, 11'd4, 1'b0));
        // Out-of-range sizes clamp to two and to the full depth.
        add_row(11'd0, make_cmd(OP_NONE, 31'd0, 32'd0, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd4, 1'b1));
        add_row(11'd2047, make_cmd(OP_READ, 31'd0, 32'd0, 10'd9), 0, '0);
        add_row(11'd2047, make_cmd(OP_NONE, 31'd0, 32'd0, 10'd0), 1,
                make_beat(10'd0, 32'd0, 11'd0, ST_DONE, 11'd4, 1'b0));

        phase_sizes = '{11'd16, 11'd2, 11'd1024, 11'd7, 11'd0, 11'd64,
                        11'd2047, 11'd31, 11'd3, 11'd100, 11'd128, 11'd1};
        phase_sizes[9] = 11'($urandom_range(2, 300));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.size != drv_size)
                write_size(row.size);
            send_cmd(row.cmd, row.typed, row.want, $urandom_range(0, 6));
        end

        // Random phases. Every third phase sends back to back.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_size(phase_sizes[p]);
            burst = (p % 3 == 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                cmd = random_cmd(clamped_size(drv_size));
                gap = burst ? 0 : $urandom_range(0, 6);
                send_cmd(cmd, 1'b0, '0, gap);
                if ($urandom_range(0, 39) == 0)
                    wait_table_idle();
            end
        end

        wait_table_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d result beats: %0d placed, %0d refused, %0d exhausted probes,",
                 beats_seen, n_placed, n_refused, n_exhausted);
        $display("%0d slot reads and %0d clears over %0d random phases",
                 n_reads, n_clears, RANDOM_PHASES);
        if (pending_beats.size() != 0)
            $display("%0d expected beats never arrived", pending_beats.size());
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("** quadratic_probe_hash_insert_unit: PASSED **");
        end else begin
            $display("%0d mismatched or unexpected beats", mismatches);
            $display("** quadratic_probe_hash_insert_unit: FAILED **");
        end
        $finish;
    end

    // Generous ceiling: far beyond the slowest correct run.
    initial begin
        #100_000_000;
        $display("timeout with %0d beats outstanding", pending_beats.size());
        $display("** quadratic_probe_hash_insert_unit: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/qphi_pkg.sv
sv/qphi_div.sv
sv/qphi_dp.sv
sv/qphi_ctrl.sv
sv/quadratic_probe_hash_insert_unit.sv
verif/quadratic_probe_hash_insert_unit_test.sv
